/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define BFFA_ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("allocator assertion failed");

// Next-cycle implication, ignored while reset is high.
`define BFFA_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("allocator assertion failed");

// Next-cycle implication that also holds across reset.
`define BFFA_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("allocator assertion failed");

`endif

/* rtl/bffa_pkg.sv */
// Package with the field widths, tag constants and request codes of the allocator.
`default_nettype none
package bffa_pkg;
  localparam int KIND_W = 1;
  localparam int SIZE_W = 17;
  localparam int ADDR_W = 16;
  localparam int ASIZE_W = 18;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  localparam logic [31:0] SIZE_MASK    = 32'hFFFF_FFF8;
  localparam logic [31:0] ALLOC_BIT    = 32'h0000_0001;
  localparam logic [31:0] TAG_OVERHEAD = 32'd8;
  localparam logic [31:0] MIN_BLOCK    = 32'd24;
  localparam logic [31:0] PROLOGUE_TAG = TAG_OVERHEAD | ALLOC_BIT;
  localparam logic [31:0] EPILOGUE_TAG = ALLOC_BIT;

  typedef logic [31:0] word_t;
  typedef logic [ASIZE_W-1:0] asize_t;
endpackage
`default_nettype wire

/* rtl/bffa_if.sv */
// Request and response channel interfaces of the allocator.
`default_nettype none
interface bffa_req_if import bffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_address;
  modport source (output valid, kind, request_size, block_address, input ready);
  modport sink (input valid, kind, request_size, block_address, output ready);
  modport monitor (input valid, ready, kind, request_size, block_address);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  logic              failed;
  modport source (output valid, granted_address, failed, input ready);
  modport sink (input valid, granted_address, failed, output ready);
  modport monitor (input valid, ready, granted_address, failed);
endinterface
`default_nettype wire

/* rtl/bffa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/best_fit_free_list_allocator_core.sv */
// Allocate: the transaction is taken in S_IDLE, each free-list block visited is read in S_W0 to S_W2,
// then tag and link work follows; a zero-size request goes straight to S_FIN.
// Free: a null address goes straight to S_FIN, otherwise dependent tag and link work follows.
// One transaction at a time with one heap access per cycle; a held response adds its stall.
// Reset is synchronous; it empties the free list, sets the heap top to 16 bytes and writes
// the prologue and epilogue tags in S_INIT1 to S_INIT3; the rest of the heap RAM is not cleared.
`default_nettype none
module best_fit_free_list_allocator_core import bffa_pkg::*; #(
  parameter int HEAP_BYTES = 65536
) (
  input wire logic clk,
  input wire logic rst,
  bffa_req_if.sink   req,
  bffa_rsp_if.source rsp
);
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int IW = AW - 2;
  localparam int WORDS = HEAP_BYTES / 4;
  localparam int VISIT_MAX = HEAP_BYTES / 8;
  localparam int VW = $clog2(VISIT_MAX) + 1;

  localparam logic [5:0] S_INIT1 = 6'd0,  S_INIT2 = 6'd1,  S_INIT3 = 6'd2,  S_IDLE = 6'd3;
  localparam logic [5:0] S_F0 = 6'd4,     S_F1 = 6'd5,     S_T0 = 6'd6,     S_T1 = 6'd7;
  localparam logic [5:0] S_J0 = 6'd8,     S_J1 = 6'd9,     S_J2 = 6'd10,    S_J3 = 6'd11;
  localparam logic [5:0] S_J4 = 6'd12,    S_A0 = 6'd13,    S_A1 = 6'd14,    S_A2 = 6'd15;
  localparam logic [5:0] S_A3 = 6'd16,    S_D0 = 6'd17,    S_D1 = 6'd18,    S_D2 = 6'd19;
  localparam logic [5:0] S_D3 = 6'd20,    S_N0 = 6'd21,    S_N1 = 6'd22,    S_B1 = 6'd23;
  localparam logic [5:0] S_C1 = 6'd24,    S_CY = 6'd25,    S_E0 = 6'd26,    S_E1 = 6'd27;
  localparam logic [5:0] S_E2 = 6'd28,    S_E3 = 6'd29,    S_E4 = 6'd30,    S_E6 = 6'd31;
  localparam logic [5:0] S_CH0 = 6'd32,   S_CH1 = 6'd33,   S_CH2 = 6'd34,   S_JEND = 6'd35;
  localparam logic [5:0] S_JRET = 6'd36,  S_W0 = 6'd37,    S_W1 = 6'd38,    S_W2 = 6'd39;
  localparam logic [5:0] S_WD = 6'd40,    S_X1 = 6'd41,    S_P0 = 6'd42,    S_P1 = 6'd43;
  localparam logic [5:0] S_P2 = 6'd44,    S_P3 = 6'd45,    S_P4 = 6'd46,    S_P5 = 6'd47;
  localparam logic [5:0] S_P6 = 6'd48,    S_P7 = 6'd49,    S_P8 = 6'd50,    S_P9 = 6'd51;
  localparam logic [5:0] S_P10 = 6'd52,   S_PW = 6'd53,    S_PW2 = 6'd54,   S_FIN = 6'd55;

  logic [5:0] state, state_next, ret, ret_next;
  word_t bp, bp_next, pb, pb_next, nb, nb_next, hd, hd_next, head, head_next;
  word_t csz, csz_next, psz, psz_next;
  logic pal, pal_next, chn, chn_next, ta, ta_next, from_alloc, from_alloc_next;
  word_t cx, cx_next, cy, cy_next, lv, lv_next, nx, nx_next;
  word_t dx, dx_next, dp, dp_next, dn, dn_next, tb, tb_next, tsz, tsz_next;
  word_t bs, bs_next, pp, pp_next, pn, pn_next, best, best_next, slack, slack_next;
  asize_t asize, asize_next;
  logic [VW-1:0] visits, visits_next;
  logic [AW:0] heap_top, heap_top_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next, out_addr;
  logic res_fail, res_fail_next, out_fail, out_valid, out_valid_next;

  logic mem_we;
  word_t mem_wa, mem_wd, mem_ra, mem_rd;

  // Heap word store.
  bffa_ram #(.WIDTH(32), .DEPTH(WORDS)) u_heap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa[AW-1:2]),
    .wdata (mem_wd),
    .raddr (mem_ra[AW-1:2]),
    .rdata (mem_rd)
  );

  // Request and response handshakes.
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.granted_address = out_addr;
  assign rsp.failed = out_fail;

  word_t rd_size, sum_rest, rp, tag;
  logic [ASIZE_W-1:0] asize_raw;
  logic [32:0] ext_sum;
  assign rd_size = mem_rd & SIZE_MASK;
  assign sum_rest = bs - word_t'(asize);
  assign rp = bp + word_t'(asize);
  assign tag = tsz | {31'b0, ta};
  assign asize_raw = (ASIZE_W'(req.request_size) + ASIZE_W'(15)) & ~ASIZE_W'(7);
  assign ext_sum = 33'(heap_top) + 33'(asize);

  // Sequencer: one heap access per state, read data used in the following state.
  always_comb begin
    state_next = state;  ret_next = ret;  bp_next = bp;  pb_next = pb;  nb_next = nb;
    hd_next = hd;  head_next = head;  csz_next = csz;  psz_next = psz;
    pal_next = pal;  chn_next = chn;  ta_next = ta;  from_alloc_next = from_alloc;
    cx_next = cx;  cy_next = cy;  lv_next = lv;  nx_next = nx;  dx_next = dx;
    dp_next = dp;  dn_next = dn;  tb_next = tb;  tsz_next = tsz;  bs_next = bs;
    pp_next = pp;  pn_next = pn;  best_next = best;  slack_next = slack;
    asize_next = asize;  visits_next = visits;  heap_top_next = heap_top;
    res_addr_next = res_addr;  res_fail_next = res_fail;
    out_valid_next = out_valid && !rsp.ready;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = '0;
    unique case (state)
      S_INIT1: begin
        mem_we = 1'b1;  mem_wa = 32'd4;  mem_wd = PROLOGUE_TAG;  state_next = S_INIT2;
      end
      S_INIT2: begin
        mem_we = 1'b1;  mem_wa = 32'd8;  mem_wd = PROLOGUE_TAG;  state_next = S_INIT3;
      end
      S_INIT3: begin
        mem_we = 1'b1;  mem_wa = 32'd12;  mem_wd = EPILOGUE_TAG;  state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          res_addr_next = '0;
          res_fail_next = 1'b0;
          from_alloc_next = (req.kind == KIND_ALLOC);
          if (req.kind == KIND_FREE) begin
            bp_next = 32'(req.block_address);
            state_next = (req.block_address == '0) ? S_FIN : S_F0;
          end else if (req.request_size == '0) begin
            res_fail_next = 1'b1;
            state_next = S_FIN;
          end else begin
            asize_next = (asize_raw < ASIZE_W'(MIN_BLOCK)) ? ASIZE_W'(MIN_BLOCK) : asize_raw;
            bp_next = head;
            best_next = '0;
            slack_next = '1;
            visits_next = '0;
            state_next = S_W0;
          end
        end
      end
      // Free: clear the allocated bit in both tags, then join.
      S_F0: begin
        mem_ra = bp - 32'd4;  state_next = S_F1;
      end
      S_F1: begin
        tb_next = bp;  tsz_next = rd_size;  ta_next = 1'b0;  ret_next = S_J0;
        state_next = S_T0;
      end
      // Tag writer.
      S_T0: begin
        mem_we = 1'b1;  mem_wa = tb - 32'd4;  mem_wd = tag;  state_next = S_T1;
      end
      S_T1: begin
        mem_we = 1'b1;  mem_wa = tb + tsz - 32'd8;  mem_wd = tag;  state_next = ret;
      end
      // Join: gather both neighbours' tags.
      S_J0: begin
        mem_ra = bp - 32'd8;  state_next = S_J1;
      end
      S_J1: begin
        pb_next = bp - rd_size;  mem_ra = bp - rd_size - 32'd4;  state_next = S_J2;
      end
      S_J2: begin
        psz_next = rd_size;  pal_next = mem_rd[0];  mem_ra = bp - 32'd4;  state_next = S_J3;
      end
      S_J3: begin
        csz_next = rd_size;  nb_next = bp + rd_size;  mem_ra = bp + rd_size - 32'd4;
        state_next = S_J4;
      end
      S_J4: begin
        hd_next = head;
        priority if (pal && mem_rd[0]) begin
          state_next = S_A0;
        end else if (mem_rd[0]) begin
          csz_next = csz + psz;  dx_next = pb;  ret_next = S_B1;  state_next = S_D0;
        end else if (pal) begin
          csz_next = csz + rd_size;  dx_next = nb;  ret_next = S_C1;  state_next = S_D0;
        end else begin
          csz_next = csz + psz + rd_size;  state_next = S_E0;
        end
      end
      // Both neighbours allocated: block goes to the list head.
      S_A0: begin
        mem_we = (bp != '0);  mem_wa = bp + 32'd8;  mem_wd = '0;  state_next = S_A1;
      end
      S_A1: begin
        mem_we = (bp != '0);  mem_wa = bp;  mem_wd = '0;
        if (hd != '0) begin
          state_next = S_A2;
        end else begin
          head_next = bp;  state_next = S_JRET;
        end
      end
      S_A2: begin
        mem_we = 1'b1;  mem_wa = hd + 32'd8;  mem_wd = bp;  state_next = S_A3;
      end
      S_A3: begin
        mem_we = (bp != '0);  mem_wa = bp;  mem_wd = hd;  head_next = bp;
        state_next = S_JRET;
      end
      // Detach dx from the list.
      S_D0: begin
        mem_ra = dx + 32'd8;  state_next = S_D1;
      end
      S_D1: begin
        dp_next = (dx == '0) ? '0 : mem_rd;  mem_ra = dx;  state_next = S_D2;
      end
      S_D2: begin
        dn_next = (dx == '0) ? '0 : mem_rd;
        if (dp == '0) begin
          state_next = ret;
        end else begin
          mem_we = 1'b1;  mem_wa = dp;  mem_wd = (dx == '0) ? '0 : mem_rd;
          state_next = S_D3;
        end
      end
      S_D3: begin
        mem_we = (dn != '0);  mem_wa = dn + 32'd8;  mem_wd = dp;  state_next = ret;
      end
      // Next link of nx into lv.
      S_N0: begin
        mem_ra = nx;
        if (nx == '0) begin
          lv_next = '0;  state_next = ret;
        end else begin
          state_next = S_N1;
        end
      end
      S_N1: begin
        lv_next = mem_rd;  state_next = ret;
      end
      // Previous neighbour free.
      S_B1: begin
        cx_next = pb;  cy_next = hd;  chn_next = (pb != hd);  state_next = S_CH0;
      end
      // Next neighbour free; the prev link of bp is cleared before the next block is read.
      S_C1: begin
        cx_next = bp;  chn_next = 1'b1;
        if (nb == hd) begin
          mem_we = (bp != '0);  mem_wa = bp + 32'd8;  mem_wd = '0;
          nx_next = nb;  ret_next = S_CY;  state_next = S_N0;
        end else begin
          cy_next = hd;  state_next = S_CH0;
        end
      end
      S_CY: begin
        cy_next = lv;  state_next = S_CH0;
      end
      // Both neighbours free: list order depends on where they sit.
      S_E0: begin
        cx_next = pb;  chn_next = 1'b1;
        priority if (pb != hd && nb != hd) begin
          dx_next = pb;  ret_next = S_E1;  state_next = S_D0;
        end else if (nb == hd) begin
          nx_next = nb;  ret_next = S_E3;  state_next = S_N0;
        end else begin
          nx_next = pb;  ret_next = S_E6;  state_next = S_N0;
        end
      end
      S_E1: begin
        dx_next = nb;  ret_next = S_E2;  state_next = S_D0;
      end
      S_E2: begin
        cy_next = hd;  state_next = S_CH0;
      end
      S_E3: begin
        if (pb == lv) begin
          nx_next = pb;  ret_next = S_CY;  state_next = S_N0;
        end else begin
          dx_next = pb;  ret_next = S_E4;  state_next = S_D0;
        end
      end
      // The prev link of pb is cleared before the next block is read.
      S_E4: begin
        mem_we = (pb != '0);  mem_wa = pb + 32'd8;  mem_wd = '0;
        nx_next = nb;  ret_next = S_CY;  state_next = S_N0;
      end
      S_E6: begin
        if (nb == lv) begin
          nx_next = nb;  ret_next = S_CY;  state_next = S_N0;
        end else begin
          cy_next = lv;  dx_next = nb;  ret_next = S_CH0;  state_next = S_D0;
        end
      end
      // Clear prev of cx and, when chn is set, chain cx to cy.
      S_CH0: begin
        mem_we = (cx != '0);  mem_wa = cx + 32'd8;  mem_wd = '0;
        state_next = chn ? S_CH1 : S_JEND;
      end
      S_CH1: begin
        mem_we = (cx != '0);  mem_wa = cx;  mem_wd = cy;  state_next = S_CH2;
      end
      S_CH2: begin
        mem_we = (cy != '0);  mem_wa = cy + 32'd8;  mem_wd = cx;  state_next = S_JEND;
      end
      S_JEND: begin
        tb_next = cx;  tsz_next = csz;  ta_next = 1'b0;  head_next = cx;  bp_next = cx;
        ret_next = S_JRET;  state_next = S_T0;
      end
      S_JRET: begin
        state_next = from_alloc ? S_P0 : S_FIN;
      end
      // Best-fit walk of the free list.
      S_W0: begin
        mem_ra = bp - 32'd4;
        if (bp == '0 || visits == VW'(VISIT_MAX)) begin
          state_next = S_WD;
        end else begin
          state_next = S_W1;
        end
      end
      S_W1: begin
        if (word_t'(asize) <= rd_size && (rd_size - word_t'(asize)) < slack) begin
          best_next = bp;  slack_next = rd_size - word_t'(asize);
        end
        mem_ra = bp;  state_next = S_W2;
      end
      S_W2: begin
        bp_next = mem_rd;  visits_next = visits + VW'(1);  state_next = S_W0;
      end
      S_WD: begin
        priority if (best != '0) begin
          bp_next = best;  state_next = S_P0;
        end else if (ext_sum > 33'(HEAP_BYTES)) begin
          res_fail_next = 1'b1;  state_next = S_FIN;
        end else begin
          bp_next = 32'(heap_top);  tb_next = 32'(heap_top);  tsz_next = word_t'(asize);
          ta_next = 1'b0;  ret_next = S_X1;  state_next = S_T0;
        end
      end
      // Heap extension: new epilogue, then join downwards.
      S_X1: begin
        mem_we = 1'b1;  mem_wa = bp + word_t'(asize) - 32'd4;  mem_wd = EPILOGUE_TAG;
        heap_top_next = heap_top + (AW+1)'(asize);
        state_next = S_J0;
      end
      // Place the request in block bp.
      S_P0: begin
        res_addr_next = bp[ADDR_W-1:0];  mem_ra = bp - 32'd4;  state_next = S_P1;
      end
      S_P1: begin
        bs_next = rd_size;  mem_ra = bp + 32'd8;  state_next = S_P2;
      end
      S_P2: begin
        pp_next = (bp == '0) ? '0 : mem_rd;  mem_ra = bp;  state_next = S_P3;
      end
      S_P3: begin
        pn_next = (bp == '0) ? '0 : mem_rd;
        tb_next = bp;  ta_next = 1'b1;
        if (bs >= word_t'(asize) && sum_rest >= MIN_BLOCK) begin
          tsz_next = word_t'(asize);  ret_next = S_P4;
        end else begin
          tsz_next = bs;  ret_next = S_PW;
        end
        state_next = S_T0;
      end
      S_P4: begin
        mem_we = (rp != '0);  mem_wa = rp + 32'd8;  mem_wd = '0;  state_next = S_P5;
      end
      S_P5: begin
        mem_we = (rp != '0);  mem_wa = rp;  mem_wd = '0;  state_next = S_P6;
      end
      S_P6: begin
        mem_we = (pn != '0) && (rp != '0);  mem_wa = rp;  mem_wd = pn;  state_next = S_P7;
      end
      S_P7: begin
        mem_we = (pn != '0);  mem_wa = pn + 32'd8;  mem_wd = rp;  state_next = S_P8;
      end
      S_P8: begin
        mem_we = (pp != '0);  mem_wa = pp;  mem_wd = rp;  state_next = S_P9;
      end
      S_P9: begin
        mem_we = (pp != '0) && (rp != '0);  mem_wa = rp + 32'd8;  mem_wd = pp;
        state_next = S_P10;
      end
      S_P10: begin
        if (bp == head) begin
          head_next = rp;
        end
        tb_next = rp;  tsz_next = sum_rest;  ta_next = 1'b0;  ret_next = S_FIN;
        state_next = S_T0;
      end
      S_PW: begin
        priority if (pp == '0 && pn == '0) begin
          head_next = '0;  state_next = S_FIN;
        end else if (pp == '0) begin
          mem_we = 1'b1;  mem_wa = pn + 32'd8;  mem_wd = '0;  head_next = pn;
          state_next = S_FIN;
        end else if (pn == '0) begin
          mem_we = 1'b1;  mem_wa = pp;  mem_wd = '0;  state_next = S_FIN;
        end else begin
          mem_we = 1'b1;  mem_wa = pp;  mem_wd = pn;  state_next = S_PW2;
        end
      end
      S_PW2: begin
        mem_we = 1'b1;  mem_wa = pn + 32'd8;  mem_wd = pp;  state_next = S_FIN;
      end
      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;  state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT1;
      head <= '0;
      heap_top <= (AW+1)'(16);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      heap_top <= heap_top_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk) begin
    ret <= ret_next;  bp <= bp_next;  pb <= pb_next;  nb <= nb_next;  hd <= hd_next;
    csz <= csz_next;  psz <= psz_next;  pal <= pal_next;
    chn <= chn_next;  ta <= ta_next;  from_alloc <= from_alloc_next;
    cx <= cx_next;  cy <= cy_next;  lv <= lv_next;  nx <= nx_next;  dx <= dx_next;
    dp <= dp_next;  dn <= dn_next;  tb <= tb_next;  tsz <= tsz_next;  bs <= bs_next;
    pp <= pp_next;  pn <= pn_next;  best <= best_next;  slack <= slack_next;
    asize <= asize_next;  visits <= visits_next;
    res_addr <= res_addr_next;  res_fail <= res_fail_next;
    if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_addr <= res_addr;
      out_fail <= res_fail;
    end
  end
endmodule
`default_nettype wire

/* rtl/bffa_checker.sv */
// Port-level checker for the allocator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module bffa_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready
);
  logic [1:0] pending;
  logic req_fire, rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Count requests taken whose response has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_fire && !rsp_fire) begin
      pending <= pending + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      pending <= pending - 2'd1;
    end
  end

  `BFFA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `BFFA_ASSERT_NEXT_ALWAYS(a_rsp_reset, clk, rst, !rsp_valid)
  `BFFA_ASSERT_IMPLY(a_rsp_has_req, clk, rst, rsp_valid, pending != 2'd0)
  `BFFA_ASSERT_IMPLY(a_no_third_req, clk, rst, pending == 2'd2, !req_ready)
endmodule

bind best_fit_free_list_allocator_core bffa_checker u_bffa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);
`default_nettype wire
